// ----- rtl/gtm_pkg.sv -----
// shared constants and widths for the gyro to mouse delta core
`timescale 1ns / 1ps
package gtm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int RATE_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int SENS_W     = 16;
    localparam int PROD_FRAC  = 24;
    localparam int SHIFT      = PROD_FRAC - FRAC_BITS;
    localparam int MUL_A_W    = RATE_W + SENS_W;
    localparam int MUL_B_W    = GAIN_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int M_W        = PROD_W - SHIFT;
    localparam int S_W        = M_W + 2;
    localparam int WHOLE_W    = S_W - FRAC_BITS;
    localparam int RES_W      = FRAC_BITS + 1;
    localparam int DELTA_W    = 16;
    localparam int DIV_R_W    = FRAC_BITS + 2;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DELTA_W-2:0] DELTA_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << 16);
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(256);

endpackage

// ----- rtl/gtm_mul.sv -----
// shared registered multiplier for gain and sensitivity scaling
`timescale 1ns / 1ps
module gtm_mul
    import gtm_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  p
);

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- rtl/gtm_div.sv -----
// bit-serial restoring divider for the low-speed curve m * 2^frac / (2 - m)
`timescale 1ns / 1ps
module gtm_div
    import gtm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FRAC_BITS-1:0] m,
    output logic                 done,
    output logic [FRAC_BITS-1:0] q
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_R_W-1:0]   r_reg;
    logic [DIV_R_W-1:0]   den_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [DIV_R_W-1:0]   r_shift;
    logic                 ge;

    always_comb
    begin
        r_shift = {r_reg[DIV_R_W-2:0], 1'b0};
        ge      = (r_shift >= den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= DIV_R_W'(m);
            den_reg <= {2'b10, {FRAC_BITS{1'b0}}} - DIV_R_W'(m);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? (r_shift - den_reg) : r_shift;
            q_reg <= {q_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ----- rtl/gyro_to_mouse_delta_core.sv -----
// gyro to mouse delta core: sequencer, residue state and output register
//
//  channel | dir | handshake        | contents
//  s       | in  | s_tvalid/tready  | tdata: rate_x, rate_y; tuser: emit
//  m       | out | m_tvalid/tready  | tdata: delta_x, delta_y; tuser: delta_valid
//  cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// the two axes run one after the other through one multiplier and one divider
// per axis: MUL1, MUL2, SCALE, CURVE, DIV when the low-speed divide runs, SIGN, ADD, SPLIT
// s_tready is high only while the sequencer is idle; a held result keeps it in ST_DONE and so blocks it
// a stalled result holds in the output register; reset clears the residues
`timescale 1ns / 1ps
module gyro_to_mouse_delta_core
    import gtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // rate_x [15:0], rate_y [31:16]
    input  logic                  s_tuser,   // emit
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // delta_x [15:0], delta_y [31:16]
    output logic                  m_tuser,   // delta_valid
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SCALE,
        ST_CURVE,
        ST_DIV,
        ST_SIGN,
        ST_ADD,
        ST_SPLIT,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic                 axis_reg;
    logic [RATE_W-1:0]    rate_x_reg;
    logic [RATE_W-1:0]    rate_y_reg;
    logic                 emit_reg;
    logic                 neg_reg;
    logic [M_W-1:0]       m_reg;
    logic signed [M_W:0]  v_reg;
    logic signed [S_W-1:0] s_reg;
    logic signed [RES_W-1:0] res_x_reg;
    logic signed [RES_W-1:0] res_y_reg;
    logic [DELTA_W-1:0]   dx_reg;
    logic [DELTA_W-1:0]   dy_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tuser_reg;
    logic [GAIN_W-1:0]    gain_x_reg;
    logic [GAIN_W-1:0]    gain_y_reg;
    logic [SENS_W-1:0]    sens_reg;

    logic [RATE_W-1:0]    rate_sel;
    logic [RATE_W-1:0]    mag;
    logic [GAIN_W-1:0]    gain_sel;
    logic signed [RES_W-1:0] res_sel;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic                 in_curve;
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] div_q;
    logic                 s_neg;
    logic [S_W-1:0]       s_abs;
    logic [WHOLE_W-1:0]   whole;
    logic [FRAC_BITS-1:0] frac;
    logic [DELTA_W-2:0]   dmag;
    logic [DELTA_W-1:0]   delta_next;
    logic signed [RES_W-1:0] res_next;

    always_comb
    begin
        rate_sel = axis_reg ? rate_y_reg : rate_x_reg;
        mag      = rate_sel[RATE_W-1] ? (~rate_sel + 1'b1) : rate_sel;
        gain_sel = axis_reg ? gain_y_reg : gain_x_reg;
        res_sel  = axis_reg ? res_y_reg : res_x_reg;
        mul_a    = (state_reg == ST_MUL1) ? MUL_A_W'(mag) : mul_p[MUL_A_W-1:0];
        mul_b    = (state_reg == ST_MUL1) ? MUL_B_W'(sens_reg) : gain_sel;
        in_curve = (m_reg != '0) && (m_reg[M_W-1:FRAC_BITS] == '0);
        div_start = (state_reg == ST_CURVE) && in_curve;

        // split the sum into whole steps and a signed fraction
        s_neg = s_reg[S_W-1];
        s_abs = s_neg ? S_W'(-s_reg) : S_W'(s_reg);
        whole = s_abs[S_W-1:FRAC_BITS];
        frac  = s_abs[FRAC_BITS-1:0];
        dmag  = (whole > WHOLE_W'(DELTA_MAX)) ? DELTA_MAX : whole[DELTA_W-2:0];
        delta_next = s_neg ? (~{1'b0, dmag} + 1'b1) : {1'b0, dmag};
        res_next   = s_neg ? -$signed({1'b0, frac}) : $signed({1'b0, frac});
    end

    gtm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    gtm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .m     (m_reg[FRAC_BITS-1:0]),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg <= GAIN_RESET;
            gain_y_reg <= GAIN_RESET;
            sens_reg   <= SENS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_X: gain_x_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_Y: gain_y_reg <= cfg_data[GAIN_W-1:0];
                CFG_SENS:   sens_reg   <= cfg_data[SENS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_CURVE;
                end
                ST_CURVE:
                begin
                    state_reg <= in_curve ? ST_DIV : ST_SIGN;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_SIGN:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    state_reg <= ST_SPLIT;
                end
                ST_SPLIT:
                begin
                    if (axis_reg)
                    begin
                        res_y_reg <= res_next;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        res_x_reg <= res_next;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rate_x_reg <= s_tdata[15:0];
                    rate_y_reg <= s_tdata[31:16];
                    emit_reg   <= s_tuser;
                end
            end
            ST_MUL1:
            begin
                neg_reg <= rate_sel[RATE_W-1];
            end
            ST_SCALE:
            begin
                m_reg <= mul_p[PROD_W-1:SHIFT];
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    m_reg <= M_W'(div_q);
                end
            end
            ST_SIGN:
            begin
                v_reg <= neg_reg ? -$signed({1'b0, m_reg}) : $signed({1'b0, m_reg});
            end
            ST_ADD:
            begin
                s_reg <= $signed({v_reg[M_W], v_reg})
                       + $signed({{(S_W-RES_W){res_sel[RES_W-1]}}, res_sel});
            end
            ST_SPLIT:
            begin
                if (axis_reg)
                begin
                    dy_reg <= delta_next;
                end
                else
                begin
                    dx_reg <= delta_next;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_reg <= {dy_reg, dx_reg};
                    m_tuser_reg <= emit_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/gtm_checker.sv -----
// port-level checks for the gyro to mouse delta core, bound to the top level
`timescale 1ns / 1ps
module gtm_checker
    import gtm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata,
    input logic                  m_tuser
);

    // one item at a time: busy right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after an input transfer");

    // a result cannot rise in the cycle right after its input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

    // saturation never gives the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
        else $error("delta outside saturation range");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind gyro_to_mouse_delta_core gtm_checker u_gtm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
